/* rtl/core/fpafi_pkg.sv */
// Package for the fixed-point ALU with result-format inference.
// Payload structs, codes and widths; no dependencies.
package fpafi_pkg;

  localparam int OperandBits = 31;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_CVT = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;

  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_FFRAC = 2'd1;
  localparam logic [1:0] MODE_FWIDTH = 2'd2;

  localparam logic [1:0] CFG_OP_MODE = 2'd0;
  localparam logic [1:0] CFG_SATURATE = 2'd1;
  localparam logic [1:0] CFG_ROUND = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] a_value;
    logic [4:0]         a_int_bits;
    logic [4:0]         a_frac_bits;
    logic [1:0]         a_type;
    logic signed [31:0] b_value;
    logic [4:0]         b_int_bits;
    logic [4:0]         b_frac_bits;
    logic [1:0]         b_type;
  } in_item_t;

  typedef struct packed {
    logic signed [62:0] result_value;
    logic [5:0]         result_int_bits;
    logic [5:0]         result_frac_bits;
    logic [1:0]         result_type;
  } out_item_t;

  typedef struct packed {
    logic       saturate;
    logic       round_nearest;
  } cfg_t;

  // stage 1 -> stage 2: operands scaled for the op, format decided
  typedef struct packed {
    logic               bad;
    logic               mul;
    logic               sub;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [5:0]         ri;
    logic [5:0]         rf;
    logic [1:0]         rt;
    logic [5:0]         sh;
  } s1_t;

  // stage 2 -> stage 3: exact value before requantisation
  typedef struct packed {
    logic               bad;
    logic signed [63:0] ex;
    logic [5:0]         ri;
    logic [5:0]         rf;
    logic [1:0]         rt;
    logic [5:0]         sh;
  } s2_t;

  // stage 3 -> stage 4: requantised value
  typedef struct packed {
    logic               bad;
    logic signed [63:0] q;
    logic [5:0]         ri;
    logic [5:0]         rf;
    logic [1:0]         rt;
  } s3_t;

  function automatic logic [4:0] clampw(input logic [4:0] v);
    clampw = (32'(v) > OperandBits) ? 5'(OperandBits) : v;
  endfunction

endpackage

/* rtl/core/fixed_point_alu_format_infer.sv */
// Fixed-point add/sub/mul/convert/negate with result-format inference: a
// four-stage pipeline (align, arithmetic, requantise, fit), each stage closed
// by a register. One transaction per cycle; a result passes the s1_r, s2_r,
// s3_r and out_r registers in turn; the whole pipeline holds while a waiting
// result sees out_stall high. Uses fpafi_pkg and the fpafi_* stages.
module fixed_point_alu_format_infer import fpafi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);
  logic [1:0] mode_r;
  logic sat_r, rnd_r;
  logic [3:0] v_r;
  logic adv;
  s1_t s1, s1_r;
  s2_t s2, s2_r;
  s3_t s3, s3_r;
  out_item_t res, out_r;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = v_r[3];
  assign out_data = out_r;

  fpafi_front u_front (.item(in_data), .op_mode(mode_r), .s1(s1));
  fpafi_arith u_arith (.s1(s1_r), .s2(s2));
  fpafi_quant u_quant (.s2(s2_r), .round_nearest(rnd_r), .s3(s3));
  fpafi_fit   u_fit   (.s3(s3_r), .saturate(sat_r), .res(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FULL;
      sat_r <= 1'b0;
      rnd_r <= 1'b0;
      v_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OP_MODE:  mode_r <= cfg_data;
          CFG_SATURATE: sat_r <= cfg_data[0];
          CFG_ROUND:    rnd_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (adv) v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1;
      s2_r <= s2;
      s3_r <= s3;
      out_r <= res;
    end
  end
endmodule

/* rtl/core/fpafi_front.sv */
// Stage 1: format inference and operand alignment.
// Uses fpafi_pkg.
module fpafi_front import fpafi_pkg::*; (
  input  in_item_t   item,
  input  logic [1:0] op_mode,
  output s1_t        s1
);
  logic [4:0] ai, af, bi, bf, mx, sel, ef5;
  logic [1:0] at, bt, md;
  logic signed [63:0] av, bv;
  logic uu, ui, uf;
  logic [5:0] ri, rf, ef;

  always_comb begin
    ai = clampw(item.a_int_bits);
    af = clampw(item.a_frac_bits);
    bi = clampw(item.b_int_bits);
    bf = clampw(item.b_frac_bits);
    at = item.a_type;
    bt = item.b_type;
    av = 64'(signed'(item.a_value[OperandBits:0]));
    bv = 64'(signed'(item.b_value[OperandBits:0]));
    md = (op_mode == 2'd3) ? MODE_FULL : op_mode;
    mx = (ai > bi) ? ai : bi;
    if (!at[1] && bt[1]) sel = bf;
    else if (!bt[1] && at[1]) sel = af;
    else sel = (af < bf) ? af : bf;
    uu = (at == 2'd1) && (bt == 2'd1);
    ui = ((at == 2'd1) && (bt == 2'd0)) || ((at == 2'd0) && (bt == 2'd1));
    uf = ((at == 2'd1) && (bt == 2'd3)) || ((at == 2'd3) && (bt == 2'd1));
    ef5 = (af > bf) ? af : bf;
    s1 = '0;
    s1.bad = item.action > ACT_NEG;
    s1.mul = item.action == ACT_MUL;
    s1.sub = (item.action == ACT_SUB) || (item.action == ACT_NEG);
    ri = '0;
    rf = '0;
    ef = '0;
    s1.rt = '0;
    unique case (item.action)
      ACT_ADD, ACT_SUB: begin
        s1.rt = (item.action == ACT_SUB) ? ((uu || ui) ? 2'd0 : 2'd2)
                : (uu ? 2'd1 : ui ? 2'd0 : uf ? 2'd3 : 2'd2);
        ef = {1'b0, ef5};
        s1.x = av <<< (ef5 - af);
        s1.y = bv <<< (ef5 - bf);
        ri = (md == MODE_FWIDTH) ? {1'b0, mx} : 6'({1'b0, mx} + 6'd1);
        rf = (md == MODE_FULL) ? ef : {1'b0, sel};
      end
      ACT_MUL: begin
        s1.rt = uu ? 2'd1 : ui ? 2'd0 : uf ? 2'd3 : 2'd2;
        ef = 6'(af) + 6'(bf);
        s1.x = av;
        s1.y = bv;
        ri = (md == MODE_FWIDTH) ? {1'b0, mx} : 6'(ai) + 6'(bi);
        rf = (md == MODE_FULL) ? ef : {1'b0, sel};
      end
      ACT_CVT: begin
        ri = {1'b0, bi};
        rf = {1'b0, bf};
        s1.rt = bt;
        if (bf >= af) begin
          s1.x = av <<< (bf - af);
          ef = {1'b0, bf};
        end else begin
          s1.x = av;
          ef = {1'b0, af};
        end
        s1.y = '0;
      end
      ACT_NEG: begin
        ri = {1'b0, ai};
        rf = {1'b0, af};
        s1.rt = at;
        s1.x = '0;
        s1.y = av;
        ef = {1'b0, af};
      end
      default: begin
        s1.x = '0;
        s1.y = '0;
      end
    endcase
    if ((7'(ri) + 7'(rf)) > 7'd62) rf = 6'd62 - ri;
    s1.ri = ri;
    s1.rf = rf;
    s1.sh = ef - rf;
  end
endmodule

/* rtl/core/fpafi_arith.sv */
// Stage 2: add, subtract or 32x32 multiply.
// Uses fpafi_pkg.
module fpafi_arith import fpafi_pkg::*; (
  input  s1_t s1,
  output s2_t s2
);
  always_comb begin
    s2.bad = s1.bad;
    s2.ri = s1.ri;
    s2.rf = s1.rf;
    s2.rt = s1.rt;
    s2.sh = s1.sh;
    if (s1.mul) s2.ex = 64'(signed'(s1.x[31:0])) * 64'(signed'(s1.y[31:0]));
    else if (s1.sub) s2.ex = s1.x - s1.y;
    else s2.ex = s1.x + s1.y;
  end
endmodule

/* rtl/core/fpafi_quant.sv */
// Stage 3: requantisation (floor or round half away from zero).
// Uses fpafi_pkg.
module fpafi_quant import fpafi_pkg::*; (
  input  s2_t  s2,
  input  logic round_nearest,
  output s3_t  s3
);
  logic [63:0] mag, add, q;
  logic        neg;
  always_comb begin
    neg = s2.ex[63];
    mag = neg ? (64'd0 - s2.ex) : s2.ex;
    if (s2.sh == 6'd0) add = '0;
    else if (round_nearest) add = 64'd1 << (s2.sh - 6'd1);
    else if (neg) add = (64'd1 << s2.sh) - 64'd1;
    else add = '0;
    q = (mag + add) >> s2.sh;
    s3.bad = s2.bad;
    s3.ri = s2.ri;
    s3.rf = s2.rf;
    s3.rt = s2.rt;
    s3.q = neg ? -$signed(q) : $signed(q);
  end
endmodule

/* rtl/core/fpafi_fit.sv */
// Stage 4: saturation or wrap into the result format.
// Uses fpafi_pkg.
module fpafi_fit import fpafi_pkg::*; (
  input  s3_t       s3,
  input  logic      saturate,
  output out_item_t res
);
  logic [6:0]  w;
  logic [63:0] mask, half, u;
  logic signed [63:0] hi, lo, q;
  always_comb begin
    w = 7'(s3.ri) + 7'(s3.rf) + (s3.rt[0] ? 7'd0 : 7'd1);
    mask = (64'd1 << w) - 64'd1;
    half = 64'd1 << (w - 7'd1);
    if (s3.rt[0]) begin
      hi = $signed(mask);
      lo = '0;
    end else begin
      hi = $signed(half - 64'd1);
      lo = -hi - 64'sd1;
    end
    q = s3.q;
    if (saturate) begin
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      u = q;
    end else if (s3.rt[0]) begin
      u = q & mask;
    end else begin
      u = ((q + half) & mask) - half;
    end
    if (s3.bad) res = '0;
    else begin
      res.result_value = u[62:0];
      res.result_int_bits = s3.ri;
      res.result_frac_bits = s3.rf;
      res.result_type = s3.rt;
    end
  end
endmodule
